// ----- src/wtcm_pkg.sv -----
// ----------------------------------------------------------------------------
// wtcm_pkg
// shared constants, types and command/status structs of the wavetable mixer
// ----------------------------------------------------------------------------
package wtcm_pkg;

    localparam int CHANNELS    = 16;
    localparam int WAVE_LENGTH = 128;
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int WAVE_AW     = $clog2(WAVE_LENGTH);
    localparam int STORE_AW    = CH_W + WAVE_AW;
    localparam int POS_W       = WAVE_AW + 8;
    localparam int ACC_W       = 44;
    localparam int MAG_W       = ACC_W - 1;
    localparam int MLO_W       = 22;
    localparam int BIG_W       = MAG_W + 16;
    localparam int REM_W       = 68;
    localparam int Q_W         = 15;
    localparam int Z_W         = 22;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SH    = 29;

    localparam logic [POS_W:0]   POS_END    = (POS_W + 1)'(WAVE_LENGTH) << 8;
    localparam logic [11:0]      STEP_MIN   = 12'd32;
    localparam logic [11:0]      STEP_MAX   = 12'd2048;
    localparam logic [11:0]      STEP_RESET = 12'd256;
    localparam logic [15:0]      GAIN_UNITY = 16'd32768;
    localparam logic [7:0]       PAN_FULL   = 8'd254;
    localparam logic [7:0]       PAN_CENTER = 8'd127;
    localparam logic [BIG_W-1:0] DIVISOR    = BIG_W'(PAN_FULL) << 45;
    // ceil(2^29 / 127): exact floor division by 127 for 22-bit operands
    localparam logic [RECIP_W-1:0] RECIP    = 23'd4227331;
    localparam logic [Q_W-1:0]   Q_MAX      = {Q_W{1'b1}};

    localparam logic [1:0] CFG_MASTER_GAIN    = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_MASK    = 2'd1;
    localparam logic [1:0] CFG_PREDICTOR_MASK = 2'd2;

    typedef enum logic [1:0] {
        KIND_MIX   = 2'd0,
        KIND_PAN   = 2'd1,
        KIND_PITCH = 2'd2,
        KIND_WAVE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            side;
        logic            clr_acc;
        logic            read;
        logic            sample;
        logic            weight;
        logic            take_abs;
        logic            mul_lo;
        logic            mul_hi;
        logic            load;
        logic            div_step;
        logic            side_end;
        logic            emit;
    } cmd_t;

    typedef struct packed {
        logic eligible;
        logic clamp;
        logic out_free;
    } stat_t;

    function automatic logic [14:0] voice_gain(input logic [CH_W-1:0] ch);
        return (ch == '0) ? 15'd22938 : 15'd9830;
    endfunction

endpackage

// ----- src/wtcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtcm_ctrl
// frame sequencer: channel walk, gain multiply and quotient step per side
// ----------------------------------------------------------------------------
module wtcm_ctrl
    import wtcm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  idle
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_SCAN     = 11'b00000000010,
        ST_SAMPLE   = 11'b00000000100,
        ST_WEIGHT   = 11'b00000001000,
        ST_ABS      = 11'b00000010000,
        ST_MUL_LO   = 11'b00000100000,
        ST_MUL_HI   = 11'b00001000000,
        ST_LOAD     = 11'b00010000000,
        ST_DIVIDE   = 11'b00100000000,
        ST_SIDE_END = 11'b01000000000,
        ST_EMIT     = 11'b10000000000
    } state_t;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    state_t          state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.side   = side_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.clr_acc = 1'b1;
                    ch_next     = '0;
                    side_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.eligible)
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_SAMPLE;
                end
                else if (ch_reg == CH_LAST)
                begin
                    state_next = ST_ABS;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_SAMPLE:
            begin
                cmd.sample = 1'b1;
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT:
            begin
                cmd.weight = 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    state_next = ST_ABS;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_ABS:
            begin
                cmd.take_abs = 1'b1;
                state_next   = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (stat.clamp)
                begin
                    state_next = ST_SIDE_END;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_SIDE_END;
            end
            ST_SIDE_END:
            begin
                cmd.side_end = 1'b1;
                if (side_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    side_next  = 1'b1;
                    state_next = ST_ABS;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |=> (state_reg == ST_SIDE_END))
        else $error("quotient step did not end the side");

    a_read_eligible: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> stat.eligible)
        else $error("wave read for a channel outside the pass");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE) && side_reg)
        else $error("emit did not end the frame");

endmodule

// ----- src/wtcm_datapath.sv -----
// ----------------------------------------------------------------------------
// wtcm_datapath
// wave store, channel state, mix accumulators, gain and quotient unit, output
// ----------------------------------------------------------------------------
module wtcm_datapath
    import wtcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        in_accept,
    input  logic [1:0]  kind,
    input  logic        predictor_pass,
    input  logic [3:0]  channel,
    input  logic [6:0]  pan_code,
    input  logic [11:0] pitch_step,
    input  logic [6:0]  wave_index,
    input  logic signed [15:0] wave_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data
);

    logic [15:0] wave_mem [2**STORE_AW];
    logic signed [15:0] rd_q;

    logic [15:0] master_reg;
    logic [15:0] active_reg;
    logic [15:0] pmask_reg;
    logic        pass_reg;

    logic [POS_W-1:0]   pos_reg   [CHANNELS];
    logic signed [15:0] pred_reg  [CHANNELS];
    logic [7:0]         pan_reg   [CHANNELS];
    logic [11:0]        step_reg  [CHANNELS];

    logic signed [31:0]    prod_reg;
    logic signed [ACC_W-1:0] accl_reg, accr_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic                  neg_reg;
    logic [BIG_W-1:0]      big_reg;
    logic [Z_W-1:0]        z_reg;
    logic [Q_W-1:0]        q_reg;
    logic [15:0]           left_reg, right_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_data_reg;

    logic                  wave_we;
    logic [11:0]           pitch_clamped;
    logic [POS_W:0]        pos_sum;
    logic signed [16:0]    pred_sum;
    logic signed [16:0]    pred_half;
    logic signed [15:0]    sample;
    logic signed [16:0]    gain_s;
    logic [7:0]            pan_r;
    logic [7:0]            pan_l;
    logic signed [40:0]    wl, wr;
    logic signed [ACC_W-1:0] acc_sel, acc_neg;
    logic [37:0]           lo_p;
    logic [36:0]           hi_p;
    logic [BIG_W+Q_W-1:0]  n_full;
    logic [Z_W+RECIP_W-1:0] recip_p;
    logic [15:0]           q_ext;
    logic [15:0]           side_res;

    assign wave_we = in_accept && (kind == KIND_WAVE);

    always_ff @(posedge clk)
    begin
        if (wave_we)
        begin
            wave_mem[{channel, wave_index}] <= wave_value;
        end
        if (cmd.read)
        begin
            rd_q <= wave_mem[{cmd.ch, pos_reg[cmd.ch][POS_W-1:8]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= GAIN_UNITY;
            active_reg <= 16'd1;
            pmask_reg  <= 16'd43690;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MASTER_GAIN:
                begin
                    master_reg <= (cfg_data > GAIN_UNITY) ? GAIN_UNITY : cfg_data;
                end
                CFG_ACTIVE_MASK:    active_reg <= cfg_data;
                CFG_PREDICTOR_MASK: pmask_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign pitch_clamped = (pitch_step < STEP_MIN) ? STEP_MIN :
                           (pitch_step > STEP_MAX) ? STEP_MAX : pitch_step;

    assign pos_sum   = {1'b0, pos_reg[cmd.ch]} + (POS_W + 1)'(step_reg[cmd.ch]);
    assign pred_sum  = 17'(rd_q) + 17'(pred_reg[cmd.ch]);
    assign pred_half = (pred_sum + 17'(pred_sum[16])) >>> 1;
    assign sample    = pass_reg ? pred_half[15:0] : rd_q;
    assign gain_s    = {2'b00, voice_gain(cmd.ch)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]  <= '0;
                pred_reg[i] <= '0;
                pan_reg[i]  <= PAN_CENTER;
                step_reg[i] <= STEP_RESET;
            end
        end
        else
        begin
            if (in_accept && (kind == KIND_MIX))
            begin
                pass_reg <= predictor_pass;
            end
            if (in_accept && (kind == KIND_PAN))
            begin
                pan_reg[channel] <= {pan_code, 1'b0};
            end
            if (in_accept && (kind == KIND_PITCH))
            begin
                step_reg[channel] <= pitch_clamped;
            end
            if (cmd.sample)
            begin
                if (pass_reg)
                begin
                    pred_reg[cmd.ch] <= pred_half[15:0];
                end
                pos_reg[cmd.ch] <= (pos_sum >= POS_END) ? '0 : pos_sum[POS_W-1:0];
            end
        end
    end

    assign pan_r   = pan_reg[cmd.ch];
    assign pan_l   = PAN_FULL - pan_r;
    assign wl      = prod_reg * $signed({1'b0, pan_l});
    assign wr      = prod_reg * $signed({1'b0, pan_r});
    assign acc_sel = cmd.side ? accr_reg : accl_reg;
    assign acc_neg = -acc_sel;
    assign lo_p    = mag_reg[MLO_W-1:0] * master_reg;
    assign hi_p    = mag_reg[MAG_W-1:MLO_W] * master_reg;
    assign n_full  = {big_reg, {Q_W{1'b0}}} - {{Q_W{1'b0}}, big_reg};
    assign recip_p = z_reg * RECIP;
    assign q_ext   = {1'b0, q_reg};
    assign side_res = neg_reg ? (16'd0 - q_ext) : q_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.sample)
        begin
            prod_reg <= 32'(sample * gain_s);
        end
        if (cmd.clr_acc)
        begin
            accl_reg <= '0;
            accr_reg <= '0;
        end
        else if (cmd.weight)
        begin
            accl_reg <= accl_reg + ACC_W'(wl);
            accr_reg <= accr_reg + ACC_W'(wr);
        end
        if (cmd.take_abs)
        begin
            neg_reg <= acc_sel[ACC_W-1];
            mag_reg <= acc_sel[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_sel[MAG_W-1:0];
        end
        if (cmd.mul_lo)
        begin
            big_reg <= {{(BIG_W - 38){1'b0}}, lo_p};
        end
        else if (cmd.mul_hi)
        begin
            big_reg <= big_reg + {hi_p, {MLO_W{1'b0}}};
        end
        // big * 32767 / 2^46, then floor division by 127 through the reciprocal
        if (cmd.load)
        begin
            q_reg <= stat.clamp ? Q_MAX : '0;
            z_reg <= n_full[REM_W-1 -: Z_W];
        end
        else if (cmd.div_step)
        begin
            q_reg <= recip_p[RECIP_SH +: Q_W];
        end
        if (cmd.side_end)
        begin
            if (cmd.side)
            begin
                right_reg <= side_res;
            end
            else
            begin
                left_reg <= side_res;
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= {right_reg, left_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.eligible = active_reg[cmd.ch] && (pmask_reg[cmd.ch] == pass_reg);
    assign stat.clamp    = (big_reg >= DIVISOR);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/wavetable_channel_mixer.sv -----
// ----------------------------------------------------------------------------
// wavetable_channel_mixer
// sixteen-voice wavetable stereo mixer with pan, pitch and predictor pass
//
//   channel   dir  handshake          payload
//   s_axis    in   tvalid/tready      tuser: kind, predictor_pass
//                                     tdata: channel, pan_code, pitch_step,
//                                            wave_index, wave_value
//   m_axis    out  tvalid/tready      tdata: left, right
//   cfg       in   cfg_we             cfg_index, cfg_data
//
// pan, pitch and wave beats are taken while idle and start no frame
// a mix frame walks the sixteen channels and weights those that play in the
// pass, then per side takes the magnitude, applies master gain as low and high
// partial products and runs the reciprocal quotient step unless it clamps
// one item at a time; a finished frame waits in the output register while
// the next beat is taken, and the frame after that holds if it is not taken
// reset sets channel state, config registers and output valid at once
// ----------------------------------------------------------------------------
module wavetable_channel_mixer
    import wtcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // channel, pan_code, pitch_step, wave_index, wave_value
    input  logic [2:0]  s_axis_tuser,  // kind, predictor_pass
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // left, right
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;
    logic  idle;
    logic  in_accept;
    logic  start;

    assign s_axis_tready = idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign start         = in_accept && (s_axis_tuser[1:0] == KIND_MIX);

    wtcm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .idle  (idle)
    );

    wtcm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_accept      (in_accept),
        .kind           (s_axis_tuser[1:0]),
        .predictor_pass (s_axis_tuser[2]),
        .channel        (s_axis_tdata[3:0]),
        .pan_code       (s_axis_tdata[10:4]),
        .pitch_step     (s_axis_tdata[22:11]),
        .wave_index     (s_axis_tdata[29:23]),
        .wave_value     (s_axis_tdata[45:30]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_data       (m_axis_tdata)
    );

endmodule
